FILE: rtl/ipf_pkg.sv
package ipf_pkg;

  localparam int HdrDepth  = 60;
  localparam int CoptDepth = 40;
  localparam int QDepth    = 4;
  localparam int IdxW      = 6;
  localparam int QPtrW     = 2;
  localparam int QCntW     = 3;

  localparam logic [15:0]     MtuReset   = 16'd1500;
  localparam logic [IdxW-1:0] BaseHdrLen = 6'd20;

  // Register index, taken from bit 2 of the byte address.
  localparam logic RegMtu  = 1'b0;
  localparam logic RegCsum = 1'b1;

  // Final status codes.
  localparam logic [2:0] StFrag   = 3'd0;
  localparam logic [2:0] StFits   = 3'd1;
  localparam logic [2:0] StDf     = 3'd2;
  localparam logic [2:0] StSmall  = 3'd3;
  localparam logic [2:0] StBadOpt = 3'd4;
  localparam logic [2:0] StTrunc  = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER, PH_FRAG, PH_FITS, PH_DF, PH_SMALL, PH_BADOPT
  } phase_t;

  typedef enum logic [2:0] {
    OP_HBYTE, OP_FIRST, OP_LATER, OP_DATA, OP_STATUS
  } op_t;

  typedef enum logic [2:0] {
    PS_TYPE, PS_LEN, PS_BODY, PS_DONE, PS_BAD
  } parse_t;

  typedef enum logic [2:0] {
    FS_ACCEPT, FS_STEP, FS_FINISH, FS_LATER, FS_DATA, FS_END
  } fstate_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_SUM_RD, BS_SUM_ACC, BS_EMIT_RD, BS_EMIT_OUT
  } bstate_t;

  // One command from the front to the back.
  typedef struct packed {
    op_t             op;
    logic [7:0]      data;
    logic            flag;    // header store write, or end of fragment
    logic [IdxW-1:0] hidx;
    logic            owe;
    logic [IdxW-1:0] oidx;
    logic [15:0]     tot;
    logic [15:0]     off;
    logic [IdxW-1:0] hlen;
    logic [IdxW-1:0] dst;
    logic [2:0]      status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: rtl/ipf_queue.sv
module ipf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipf_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output ipf_pkg::cmd_t  head,
  output ipf_pkg::qstat_t stat
);

  ipf_pkg::cmd_t                  mem_r [ipf_pkg::QDepth];
  logic [ipf_pkg::QPtrW-1:0]      wp_r;
  logic [ipf_pkg::QPtrW-1:0]      rp_r;
  logic [ipf_pkg::QCntW-1:0]      cnt_r;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == ipf_pkg::QCntW'(ipf_pkg::QDepth));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ipf_front.sv
module ipf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic [15:0]     mtu,
  output logic            q_push,
  output ipf_pkg::cmd_t   q_cmd,
  input  ipf_pkg::qstat_t q_stat
);

  ipf_pkg::fstate_t fst_r, fst_nxt;
  ipf_pkg::phase_t  phase_r;
  ipf_pkg::phase_t  dec_phase;
  ipf_pkg::parse_t  ps_r, ps_nxt;

  logic [7:0]  byte_r;
  logic        end_r;
  logic [15:0] p_r;
  logic [15:0] bcnt_r;
  logic [15:0] fdc_r;
  logic [3:0]  ihl_r;
  logic [15:0] tot_r;
  logic [15:0] off_r;
  logic [5:0]  dst_r, dst_nxt;
  logic [7:0]  bleft_r, bleft_nxt;
  logic        cpy_r, cpy_nxt;
  logic [15:0] lstep_r;
  logic [5:0]  fhl_r;

  logic [5:0]  hl;
  logic [15:0] hl16;
  logic        in_opt;
  logic        data_in;
  logic [5:0]  opt_cnt;
  logic        owe;
  logic [5:0]  oidx;
  logic        in_acc;
  logic        need_push;
  logic        adv;
  logic        after_end;
  logic [5:0]  pad;
  logic [5:0]  fhl_calc;
  logic [15:0] fdc_first;
  logic [15:0] flen;
  logic [15:0] lstep_calc;
  logic [15:0] rem;
  logic        last;
  logic [15:0] len;
  logic [15:0] seg;
  logic [12:0] off_lo;
  logic [2:0]  off_hi;
  logic [15:0] ltot;
  logic [2:0]  st;

  assign hl      = (ihl_r < 4'd5) ? ipf_pkg::BaseHdrLen : {ihl_r, 2'b00};
  assign hl16    = {10'd0, hl};
  assign in_opt  = (p_r >= 16'd20) && (p_r < hl16);
  assign data_in = (p_r < tot_r) && (p_r >= hl16);
  assign opt_cnt = hl - p_r[5:0];
  assign in_acc  = in_tvalid && in_tready;

  // Option parsing runs on the fly as the option bytes arrive.
  always_comb begin
    ps_nxt    = ps_r;
    dst_nxt   = dst_r;
    bleft_nxt = bleft_r;
    cpy_nxt   = cpy_r;
    owe       = 1'b0;
    oidx      = dst_r;
    if (in_opt) begin
      unique case (ps_r)
        ipf_pkg::PS_TYPE: begin
          if (byte_r == 8'd0) begin
            ps_nxt = ipf_pkg::PS_DONE;
          end else if (byte_r == 8'd1) begin
            owe     = 1'b1;
            dst_nxt = dst_r + 6'd1;
          end else if (opt_cnt < 6'd2) begin
            ps_nxt = ipf_pkg::PS_BAD;
          end else begin
            // The type byte is written ahead; it only counts once the length is good.
            owe     = byte_r[7];
            cpy_nxt = byte_r[7];
            ps_nxt  = ipf_pkg::PS_LEN;
          end
        end
        ipf_pkg::PS_LEN: begin
          if (byte_r < 8'd2 || byte_r > ({2'b00, opt_cnt} + 8'd1)) begin
            ps_nxt = ipf_pkg::PS_BAD;
          end else begin
            owe  = cpy_r;
            oidx = dst_r + 6'd1;
            if (cpy_r) begin
              dst_nxt = dst_r + 6'd2;
            end
            bleft_nxt = byte_r - 8'd2;
            ps_nxt    = (byte_r == 8'd2) ? ipf_pkg::PS_TYPE : ipf_pkg::PS_BODY;
          end
        end
        ipf_pkg::PS_BODY: begin
          owe = cpy_r;
          if (cpy_r) begin
            dst_nxt = dst_r + 6'd1;
          end
          bleft_nxt = bleft_r - 8'd1;
          if (bleft_r == 8'd1) begin
            ps_nxt = ipf_pkg::PS_TYPE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Decision once the header is complete.
  assign pad        = (dst_r + 6'd3) & 6'b111100;
  assign fhl_calc   = ipf_pkg::BaseHdrLen + pad;
  assign fdc_first  = (mtu - hl16) & 16'hFFF8;
  assign flen       = hl16 + fdc_first;
  assign lstep_calc = (mtu - {10'd0, fhl_calc}) & 16'hFFF8;

  always_comb begin
    if (tot_r <= mtu) begin
      dec_phase = ipf_pkg::PH_FITS;
    end else if (off_r[14]) begin
      dec_phase = ipf_pkg::PH_DF;
    end else if (mtu < (hl16 + 16'd8)) begin
      dec_phase = ipf_pkg::PH_SMALL;
    end else if (ihl_r < 4'd5 || ps_r == ipf_pkg::PS_BAD) begin
      dec_phase = ipf_pkg::PH_BADOPT;
    end else begin
      dec_phase = ipf_pkg::PH_FRAG;
    end
  end

  // Later fragment header fields.
  assign rem    = tot_r - p_r;
  assign last   = (rem <= lstep_r);
  assign len    = last ? rem : lstep_r;
  assign seg    = p_r - hl16;
  assign off_lo = off_r[12:0] + seg[15:3];
  assign off_hi = off_r[15:13] | {2'b00, ~last};
  assign ltot   = {10'd0, fhl_r} + len;

  always_comb begin
    unique case (phase_r)
      ipf_pkg::PH_FRAG:   st = (bcnt_r < tot_r) ? ipf_pkg::StTrunc : ipf_pkg::StFrag;
      ipf_pkg::PH_FITS:   st = (bcnt_r < tot_r) ? ipf_pkg::StTrunc : ipf_pkg::StFits;
      ipf_pkg::PH_DF:     st = ipf_pkg::StDf;
      ipf_pkg::PH_SMALL:  st = ipf_pkg::StSmall;
      ipf_pkg::PH_BADOPT: st = ipf_pkg::StBadOpt;
      default:            st = ipf_pkg::StTrunc;
    endcase
  end

  always_comb begin
    unique case (fst_r) inside
      ipf_pkg::FS_STEP:   need_push = (phase_r == ipf_pkg::PH_HEADER);
      ipf_pkg::FS_FINISH: need_push = (dec_phase == ipf_pkg::PH_FRAG);
      ipf_pkg::FS_LATER,
      ipf_pkg::FS_DATA,
      ipf_pkg::FS_END:    need_push = 1'b1;
      default:            need_push = 1'b0;
    endcase
  end

  assign adv       = !need_push || !q_stat.full;
  assign after_end = end_r;

  // Next state.
  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r) inside
      ipf_pkg::FS_ACCEPT: begin
        if (in_tvalid) begin
          fst_nxt = ipf_pkg::FS_STEP;
        end
      end
      ipf_pkg::FS_STEP: begin
        if (adv) begin
          if (phase_r == ipf_pkg::PH_HEADER && bcnt_r == hl16) begin
            fst_nxt = ipf_pkg::FS_FINISH;
          end else if (phase_r == ipf_pkg::PH_FRAG && data_in) begin
            fst_nxt = (fdc_r == 16'd0) ? ipf_pkg::FS_LATER : ipf_pkg::FS_DATA;
          end else begin
            fst_nxt = after_end ? ipf_pkg::FS_END : ipf_pkg::FS_ACCEPT;
          end
        end
      end
      ipf_pkg::FS_FINISH,
      ipf_pkg::FS_DATA: begin
        if (adv) begin
          fst_nxt = after_end ? ipf_pkg::FS_END : ipf_pkg::FS_ACCEPT;
        end
      end
      ipf_pkg::FS_LATER: begin
        if (adv) begin
          fst_nxt = ipf_pkg::FS_DATA;
        end
      end
      ipf_pkg::FS_END: begin
        if (adv) begin
          fst_nxt = ipf_pkg::FS_ACCEPT;
        end
      end
      default: fst_nxt = ipf_pkg::FS_ACCEPT;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = (fst_r == ipf_pkg::FS_ACCEPT);
    q_push    = need_push && !q_stat.full;
    q_cmd     = '0;
    unique case (fst_r)
      ipf_pkg::FS_STEP: begin
        q_cmd.op   = ipf_pkg::OP_HBYTE;
        q_cmd.data = byte_r;
        q_cmd.flag = (p_r < 16'd60);
        q_cmd.hidx = p_r[5:0];
        q_cmd.owe  = owe;
        q_cmd.oidx = oidx;
      end
      ipf_pkg::FS_FINISH: begin
        q_cmd.op   = ipf_pkg::OP_FIRST;
        q_cmd.tot  = flen;
        q_cmd.off  = off_r | 16'h2000;
        q_cmd.hlen = hl;
        q_cmd.dst  = dst_r;
      end
      ipf_pkg::FS_LATER: begin
        q_cmd.op   = ipf_pkg::OP_LATER;
        q_cmd.tot  = ltot;
        q_cmd.off  = {off_hi, off_lo};
        q_cmd.hlen = fhl_r;
        q_cmd.dst  = dst_r;
      end
      ipf_pkg::FS_DATA: begin
        q_cmd.op   = ipf_pkg::OP_DATA;
        q_cmd.data = byte_r;
        q_cmd.flag = (fdc_r == 16'd1);
      end
      ipf_pkg::FS_END: begin
        q_cmd.op     = ipf_pkg::OP_STATUS;
        q_cmd.status = st;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte;
      end_r  <= in_end;
      p_r    <= bcnt_r;
    end
    if (fst_r == ipf_pkg::FS_STEP && phase_r == ipf_pkg::PH_HEADER && adv) begin
      bleft_r <= bleft_nxt;
      cpy_r   <= cpy_nxt;
      if (p_r == 16'd0) begin
        ihl_r <= byte_r[3:0];
        ps_r  <= ipf_pkg::PS_TYPE;
        dst_r <= '0;
      end else begin
        ps_r  <= ps_nxt;
        dst_r <= dst_nxt;
      end
      if (p_r == 16'd2) tot_r[15:8] <= byte_r;
      if (p_r == 16'd3) tot_r[7:0]  <= byte_r;
      if (p_r == 16'd6) off_r[15:8] <= byte_r;
      if (p_r == 16'd7) off_r[7:0]  <= byte_r;
    end
    if (fst_r == ipf_pkg::FS_FINISH && dec_phase == ipf_pkg::PH_FRAG) begin
      lstep_r <= lstep_calc;
      fhl_r   <= fhl_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r   <= ipf_pkg::FS_ACCEPT;
      phase_r <= ipf_pkg::PH_HEADER;
      bcnt_r  <= '0;
      fdc_r   <= '0;
    end else begin
      fst_r <= fst_nxt;
      if (in_acc && bcnt_r != 16'hFFFF) begin
        bcnt_r <= bcnt_r + 16'd1;
      end
      unique case (fst_r)
        ipf_pkg::FS_FINISH: begin
          if (adv) begin
            phase_r <= dec_phase;
            if (dec_phase == ipf_pkg::PH_FRAG) begin
              fdc_r <= fdc_first;
            end
          end
        end
        ipf_pkg::FS_LATER: begin
          if (adv) fdc_r <= len;
        end
        ipf_pkg::FS_DATA: begin
          if (adv) fdc_r <= fdc_r - 16'd1;
        end
        ipf_pkg::FS_END: begin
          if (adv) begin
            phase_r <= ipf_pkg::PH_HEADER;
            bcnt_r  <= '0;
            fdc_r   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/ipf_back.sv
module ipf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            csum_en,
  output logic            q_pop,
  input  ipf_pkg::cmd_t   q_head,
  input  ipf_pkg::qstat_t q_stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output logic [7:0]      out_byte,
  output logic            frag_end,
  output logic [2:0]      status,
  output logic            packet_done
);

  ipf_pkg::bstate_t bst_r, bst_nxt;
  ipf_pkg::cmd_t    cmd_r;

  logic [7:0]  hs_mem [ipf_pkg::HdrDepth];
  logic [7:0]  co_mem [ipf_pkg::CoptDepth];
  logic [7:0]  hs_rd_r;
  logic [7:0]  co_rd_r;
  logic [5:0]  j_r;
  logic [15:0] acc_r;
  logic        cen_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic        frag_end_r;
  logic [2:0]  status_r;
  logic        done_r;

  logic        out_free;
  logic        load;
  logic        ld_kind;
  logic [7:0]  ld_byte;
  logic        ld_fend;
  logic [2:0]  ld_status;
  logic        ld_done;

  logic        later;
  logic        hdr_last;
  logic [5:0]  co_addr;
  logic [5:0]  co_off;
  logic [7:0]  src;
  logic [15:0] csw;
  logic [7:0]  hb;
  logic [15:0] word;
  logic [16:0] s17;
  logic [15:0] acc_add;
  logic        head_hdr;

  assign out_free = !out_valid_r || out_ready;
  assign later    = (cmd_r.op == ipf_pkg::OP_LATER);
  assign hdr_last = (j_r == cmd_r.hlen - 6'd1);
  assign co_off   = j_r - 6'd20;
  assign co_addr  = (j_r >= 6'd20) ? co_off : 6'd0;
  assign head_hdr = (q_head.op == ipf_pkg::OP_FIRST) || (q_head.op == ipf_pkg::OP_LATER);

  // Checksum bytes count as zero in the summing pass.
  assign csw = (bst_r == ipf_pkg::BS_EMIT_OUT && cen_r) ? ~acc_r : 16'd0;

  always_comb begin
    if (later && j_r >= 6'd20) begin
      src = (co_off < cmd_r.dst) ? co_rd_r : 8'd0;
    end else begin
      src = hs_rd_r;
    end
    case (j_r)
      6'd0:    hb = later ? {src[7:4], cmd_r.hlen[5:2]} : src;
      6'd2:    hb = cmd_r.tot[15:8];
      6'd3:    hb = cmd_r.tot[7:0];
      6'd6:    hb = cmd_r.off[15:8];
      6'd7:    hb = cmd_r.off[7:0];
      6'd10:   hb = csw[15:8];
      6'd11:   hb = csw[7:0];
      default: hb = src;
    endcase
  end

  // One's complement sum with the carry folded back at each byte.
  assign word    = j_r[0] ? {8'd0, hb} : {hb, 8'd0};
  assign s17     = {1'b0, acc_r} + {1'b0, word};
  assign acc_add = s17[15:0] + {15'd0, s17[16]};

  // Next state.
  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      ipf_pkg::BS_IDLE: begin
        if (!q_stat.empty && head_hdr) begin
          bst_nxt = csum_en ? ipf_pkg::BS_SUM_RD : ipf_pkg::BS_EMIT_RD;
        end
      end
      ipf_pkg::BS_SUM_RD:  bst_nxt = ipf_pkg::BS_SUM_ACC;
      ipf_pkg::BS_SUM_ACC: bst_nxt = hdr_last ? ipf_pkg::BS_EMIT_RD : ipf_pkg::BS_SUM_RD;
      ipf_pkg::BS_EMIT_RD: bst_nxt = ipf_pkg::BS_EMIT_OUT;
      ipf_pkg::BS_EMIT_OUT: begin
        if (out_free) begin
          bst_nxt = hdr_last ? ipf_pkg::BS_IDLE : ipf_pkg::BS_EMIT_RD;
        end
      end
      default: bst_nxt = ipf_pkg::BS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    ld_kind   = 1'b0;
    ld_byte   = 8'd0;
    ld_fend   = 1'b0;
    ld_status = 3'd0;
    ld_done   = 1'b0;
    unique case (bst_r)
      ipf_pkg::BS_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_head.op)
            ipf_pkg::OP_DATA: begin
              q_pop   = out_free;
              load    = out_free;
              ld_byte = q_head.data;
              ld_fend = q_head.flag;
            end
            ipf_pkg::OP_STATUS: begin
              q_pop     = out_free;
              load      = out_free;
              ld_kind   = 1'b1;
              ld_status = q_head.status;
              ld_done   = 1'b1;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ipf_pkg::BS_EMIT_OUT: begin
        load    = out_free;
        ld_byte = hb;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == ipf_pkg::OP_HBYTE) begin
      if (q_head.flag) begin
        hs_mem[q_head.hidx] <= q_head.data;
      end
      if (q_head.owe && q_head.oidx < 6'(ipf_pkg::CoptDepth)) begin
        co_mem[q_head.oidx] <= q_head.data;
      end
    end
    hs_rd_r <= hs_mem[j_r];
    co_rd_r <= co_mem[co_addr];
  end

  always_ff @(posedge clk) begin
    if (bst_r == ipf_pkg::BS_IDLE) begin
      cmd_r <= q_head;
      cen_r <= csum_en;
    end
    if (load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      frag_end_r <= ld_fend;
      status_r   <= ld_status;
      done_r     <= ld_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= ipf_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      acc_r       <= '0;
    end else begin
      bst_r <= bst_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (bst_r)
        ipf_pkg::BS_IDLE: begin
          j_r   <= '0;
          acc_r <= '0;
        end
        ipf_pkg::BS_SUM_ACC: begin
          acc_r <= acc_add;
          j_r   <= hdr_last ? 6'd0 : j_r + 6'd1;
        end
        ipf_pkg::BS_EMIT_OUT: begin
          if (out_free && !hdr_last) begin
            j_r <= j_r + 6'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_byte    = out_byte_r;
  assign frag_end    = frag_end_r;
  assign status      = status_r;
  assign packet_done = done_r;

endmodule

FILE: rtl/ipv4_packet_fragmenter.sv
// Channel  Direction  tdata                                  tlast      tuser
// in_      slave      [7:0] in_byte                          in_end     -
// out_     master     [7:0] out_byte, [10:8] status,         frag_end   out_kind
//                     [11] packet_done, [15:12] zero
// cfg_     APB        0x0 mtu [15:0], 0x4 checksum_enable [0]
//
// Each input word is accepted and then classified, and a data word is then forwarded; the
// header's last word, a word that opens a later fragment and the word that ends the packet
// each pass one more state (finish, later header, status), and a full queue stalls them.
// The emitter takes a fragment header of L bytes as a pop, then with the checksum on a read
// and an add per byte, then a read and a send per byte; with it off, the summing is skipped.
// Reset is synchronous and active low; the header and option stores need no clearing.
// The four-entry command queue lets input keep flowing while the output is stalled.
module ipv4_packet_fragmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [11] packet_done
  output logic        out_tlast,
  output logic        out_tuser,  // [0] out_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0]     mtu_r;
  logic            cen_r;
  logic            cfg_wr;
  logic            q_push;
  logic            q_pop;
  ipf_pkg::cmd_t   q_cmd;
  ipf_pkg::cmd_t   q_head;
  ipf_pkg::qstat_t q_stat;
  logic [7:0]      o_byte;
  logic [2:0]      o_status;
  logic            o_done;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ipf_pkg::RegCsum) ? {31'd0, cen_r} : {16'd0, mtu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= ipf_pkg::MtuReset;
      cen_r <= 1'b1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ipf_pkg::RegMtu) begin
        mtu_r <= cfg_pwdata[15:0];
      end else begin
        cen_r <= cfg_pwdata[0];
      end
    end
  end

  ipf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .mtu       (mtu_r),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_stat    (q_stat)
  );

  ipf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  ipf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .csum_en     (cen_r),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .q_stat      (q_stat),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_byte    (o_byte),
    .frag_end    (out_tlast),
    .status      (o_status),
    .packet_done (o_done)
  );

  assign out_tdata = {4'd0, o_done, o_status, o_byte};

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_mtu_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == ipf_pkg::RegMtu) |=> (mtu_r == $past(cfg_pwdata[15:0])))
    else $error("mtu register not updated by write");

  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (o_done && o_byte == 8'd0 && !out_tlast))
    else $error("status word malformed");

  a_byte_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (!o_done && o_status == 3'd0))
    else $error("fragment byte carries status");
`endif

endmodule
